/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds whenever out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/srrp_pkg.sv */
// ----------------------------------------------------------------------------
// srrp_pkg
// types and codes of the sensor report, retry and pairing block
// ----------------------------------------------------------------------------
package srrp_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_RX     = 2'd1,
      MODE_BUTTON = 2'd2,
      MODE_SEND   = 2'd3
   } mode_type;

   // packet opcodes
   localparam logic [7:0] OP_DATA       = 8'h00;
   localparam logic [7:0] OP_PAIR       = 8'h01;
   localparam logic [7:0] OP_ACK        = 8'h80;
   localparam logic [7:0] OP_PAIR_REPLY = 8'h81;

   // led events
   localparam logic [1:0] LED_NONE   = 2'd0;
   localparam logic [1:0] LED_FLASH  = 2'd1;
   localparam logic [1:0] LED_TRIPLE = 2'd2;
   localparam logic [1:0] LED_ON     = 2'd3;

   // csr indexes
   localparam logic [2:0] REG_SENSOR_ID     = 3'd0;
   localparam logic [2:0] REG_INITIAL_BASE  = 3'd1;
   localparam logic [2:0] REG_REPLY_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_MAX_SENDS     = 3'd3;
   localparam logic [2:0] REG_PAIRING_TICKS = 3'd4;

   // csr reset values
   localparam logic [7:0] RST_REPLY_TIMEOUT = 8'd100;
   localparam logic [7:0] RST_MAX_SENDS     = 8'd5;
   localparam logic [7:0] RST_PAIRING_TICKS = 8'd100;

   // one result beat
   typedef struct packed {
      logic       has_packet;
      logic [7:0] tx_dest;
      logic [7:0] tx_src;
      logic [7:0] tx_opcode;
      logic [7:0] tx_temp;
      logic [7:0] tx_batt;
      logic       sleep_request;
      logic       pairing_active;
      logic [7:0] current_base;
      logic       store_base;
      logic [1:0] led_event;
      logic       last;
   } result_type;

   // handoff from core to result buffer
   typedef struct packed {
      logic push;
      logic two;
   } push_type;

endpackage

/* hdl/srrp_core.sv */
// ----------------------------------------------------------------------------
// srrp_core
// protocol state, csr registers and result generation for one item
// ----------------------------------------------------------------------------
module srrp_core
   import srrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] mode,
   input  logic [7:0] rx_first,
   input  logic [7:0] rx_second,
   input  logic [7:0] rx_opcode,
   input  logic [7:0] temperature,
   input  logic [7:0] battery,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   output push_type   push,
   output result_type res0,
   output result_type res1
);

   // csr registers
   logic [7:0] sensor_id_ff, reply_timeout_ff, max_sends_ff, pairing_ticks_ff;
   // protocol state
   logic [7:0] reply_timer_ff, pairing_timer_ff, send_count_ff, base_id_ff;
   logic       pairing_flag_ff, sleep_flag_ff;
   logic [7:0] reply_timer_in, pairing_timer_in, send_count_in, base_id_in;
   logic       pairing_flag_in, sleep_flag_in;

   result_type pkt0, pkt1;
   logic [1:0] npkt;
   logic [1:0] idle_led;
   mode_type   mode_sel;

   function automatic result_type make_pkt(input logic [7:0] dest, input logic [7:0] src,
                                           input logic [7:0] op, input logic [7:0] t,
                                           input logic [7:0] b, input logic store,
                                           input logic [1:0] led);
      result_type r;
      r                = '0;
      r.has_packet     = 1'b1;
      r.tx_dest        = dest;
      r.tx_src         = src;
      r.tx_opcode      = op;
      r.tx_temp        = t;
      r.tx_batt        = b;
      r.store_base     = store;
      r.led_event      = led;
      return r;
   endfunction

   assign mode_sel = mode_type'(mode);

   // next state and packets, in the order the protocol handles events
   always_comb begin
      reply_timer_in   = reply_timer_ff;
      pairing_timer_in = pairing_timer_ff;
      send_count_in    = send_count_ff;
      base_id_in       = base_id_ff;
      pairing_flag_in  = pairing_flag_ff;
      sleep_flag_in    = sleep_flag_ff;
      pkt0             = '0;
      pkt1             = '0;
      npkt             = 2'd0;
      idle_led         = LED_NONE;
      unique case (mode_sel)
         MODE_TICK: begin
            // reply timer first
            if (reply_timer_in != 8'd0) begin
               reply_timer_in = reply_timer_in - 8'd1;
               if (reply_timer_in == 8'd0) begin
                  if (send_count_in < max_sends_ff) begin
                     pkt0 = make_pkt(base_id_in, sensor_id_ff, OP_DATA, temperature,
                                     battery, 1'b0, LED_FLASH);
                     npkt = 2'd1;
                     reply_timer_in = reply_timeout_ff;
                     send_count_in  = send_count_in + 8'd1;
                  end else begin
                     sleep_flag_in = 1'b1;
                  end
               end
            end
            // then pairing timer
            if (pairing_timer_in != 8'd0) begin
               pairing_timer_in = pairing_timer_in - 8'd1;
               if (pairing_timer_in == 8'd0) begin
                  pairing_flag_in = 1'b0;
                  send_count_in   = 8'd0;
                  if (max_sends_ff != 8'd0) begin
                     if (npkt == 2'd0) begin
                        pkt0 = make_pkt(base_id_in, sensor_id_ff, OP_DATA, temperature,
                                        battery, 1'b0, LED_FLASH);
                     end else begin
                        pkt1 = make_pkt(base_id_in, sensor_id_ff, OP_DATA, temperature,
                                        battery, 1'b0, LED_FLASH);
                     end
                     npkt = npkt + 2'd1;
                     reply_timer_in = reply_timeout_ff;
                     send_count_in  = 8'd1;
                  end else begin
                     sleep_flag_in = 1'b1;
                  end
               end
            end
         end
         MODE_RX: begin
            if (pairing_flag_ff) begin
               // broadcast pairing packet
               if (rx_first == 8'd0 && rx_opcode == OP_PAIR) begin
                  base_id_in      = rx_second;
                  pairing_flag_in = 1'b0;
                  reply_timer_in  = 8'd0;
                  send_count_in   = 8'd0;
                  if (max_sends_ff != 8'd0) begin
                     pkt0 = make_pkt(rx_second, sensor_id_ff, OP_PAIR_REPLY, 8'd0, 8'd0,
                                     1'b1, LED_NONE);
                     pkt1 = make_pkt(rx_second, sensor_id_ff, OP_DATA, temperature,
                                     battery, 1'b0, LED_TRIPLE);
                     npkt = 2'd2;
                     reply_timer_in = reply_timeout_ff;
                     send_count_in  = 8'd1;
                  end else begin
                     pkt0 = make_pkt(rx_second, sensor_id_ff, OP_PAIR_REPLY, 8'd0, 8'd0,
                                     1'b1, LED_TRIPLE);
                     npkt = 2'd1;
                     sleep_flag_in = 1'b1;
                  end
               end
            end else if (rx_first == sensor_id_ff && rx_second == base_id_ff &&
                         rx_opcode == OP_ACK) begin
               // acknowledge of our data
               reply_timer_in = 8'd0;
               send_count_in  = 8'd0;
               sleep_flag_in  = 1'b1;
            end
         end
         MODE_BUTTON: begin
            reply_timer_in   = 8'd0;
            send_count_in    = 8'd0;
            sleep_flag_in    = 1'b0;
            pairing_flag_in  = 1'b1;
            pairing_timer_in = pairing_ticks_ff;
            idle_led         = LED_ON;
         end
         MODE_SEND: begin
            if (send_count_ff < max_sends_ff) begin
               pkt0 = make_pkt(base_id_ff, sensor_id_ff, OP_DATA, temperature, battery,
                               1'b0, LED_FLASH);
               npkt = 2'd1;
               reply_timer_in = reply_timeout_ff;
               send_count_in  = send_count_ff + 8'd1;
            end else begin
               sleep_flag_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result beats with status after the item
   always_comb begin
      res0 = pkt0;
      res1 = pkt1;
      if (npkt == 2'd0) begin
         res0.led_event = idle_led;
      end
      res0.sleep_request  = sleep_flag_in;
      res0.pairing_active = pairing_flag_in;
      res0.current_base   = base_id_in;
      res0.last           = (npkt != 2'd2);
      res1.sleep_request  = sleep_flag_in;
      res1.pairing_active = pairing_flag_in;
      res1.current_base   = base_id_in;
      res1.last           = 1'b1;
      push.push           = accept;
      push.two            = (npkt == 2'd2);
   end

   // csr and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff     <= 8'd0;
         reply_timeout_ff <= RST_REPLY_TIMEOUT;
         max_sends_ff     <= RST_MAX_SENDS;
         pairing_ticks_ff <= RST_PAIRING_TICKS;
         reply_timer_ff   <= 8'd0;
         pairing_timer_ff <= 8'd0;
         send_count_ff    <= 8'd0;
         base_id_ff       <= 8'd0;
         pairing_flag_ff  <= 1'b0;
         sleep_flag_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_SENSOR_ID:     sensor_id_ff     <= csr_data;
               REG_INITIAL_BASE:  base_id_ff       <= csr_data;
               REG_REPLY_TIMEOUT: reply_timeout_ff <= csr_data;
               REG_MAX_SENDS:     max_sends_ff     <= csr_data;
               REG_PAIRING_TICKS: pairing_ticks_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            reply_timer_ff   <= reply_timer_in;
            pairing_timer_ff <= pairing_timer_in;
            send_count_ff    <= send_count_in;
            base_id_ff       <= base_id_in;
            pairing_flag_ff  <= pairing_flag_in;
            sleep_flag_ff    <= sleep_flag_in;
         end
      end
   end

endmodule

/* hdl/srrp_rsp_buf.sv */
// ----------------------------------------------------------------------------
// srrp_rsp_buf
// two-beat result buffer between the core and the response channel
// ----------------------------------------------------------------------------
module srrp_rsp_buf
   import srrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  result_type res0,
   input  result_type res1,
   output logic       ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp
);

   result_type slot0_ff, slot1_ff;
   logic [1:0] count_ff;
   logic       take;

   assign rsp_valid = (count_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   // room for a full item once the head beat leaves
   assign ready     = (count_ff == 2'd0) || (count_ff == 2'd1 && take);
   assign rsp       = slot0_ff;

   // payload slots
   always_ff @(posedge clock) begin
      if (push.push && ready) begin
         slot0_ff <= res0;
         slot1_ff <= res1;
      end else if (take) begin
         slot0_ff <= slot1_ff;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (push.push && ready) begin
         count_ff <= push.two ? 2'd2 : 2'd1;
      end else if (take) begin
         count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* hdl/sensor_report_retry_pairing.sv */
// ----------------------------------------------------------------------------
// sensor_report_retry_pairing
// sensor-side data report, retry and pairing link protocol
// ----------------------------------------------------------------------------
// Request beats carry one event: a tick, a received packet, the pairing button
// or a start of sending. Each request gives one or two response beats; the
// final one of a request has rsp_last set. A beat with rsp_has_packet set
// holds a packet to transmit, and every beat reports the sleep, pairing and
// base id status after the request.
// Latency: the first response beat is valid the cycle after the request is
// accepted. A new request is taken as the final beat of the one before leaves;
// the response port gives one beat per cycle while rsp_stall is low.
// The csr port writes the five registers by index; writing the initial base id
// also loads the base id in use. Write csr only while the block is idle.
// Reset clears all timers, counts and flags, loads the csr reset values and
// empties the response buffer. When the receiver stalls, the buffered beats
// hold and req_stall rises once a new request no longer fits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_report_retry_pairing
   import srrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_first,
   input  logic [7:0] req_rx_second,
   input  logic [7:0] req_rx_opcode,
   input  logic [7:0] req_temperature,
   input  logic [7:0] req_battery,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_packet,
   output logic [7:0] rsp_tx_dest,
   output logic [7:0] rsp_tx_src,
   output logic [7:0] rsp_tx_opcode,
   output logic [7:0] rsp_tx_temp,
   output logic [7:0] rsp_tx_batt,
   output logic       rsp_sleep_request,
   output logic       rsp_pairing_active,
   output logic [7:0] rsp_current_base,
   output logic       rsp_store_base,
   output logic [1:0] rsp_led_event,
   output logic       rsp_last,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   logic       ready;
   logic       accept;
   push_type   push;
   result_type res0, res1, rsp;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   // protocol core
   srrp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_mode),
      .rx_first    (req_rx_first),
      .rx_second   (req_rx_second),
      .rx_opcode   (req_rx_opcode),
      .temperature (req_temperature),
      .battery     (req_battery),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push),
      .res0        (res0),
      .res1        (res1)
   );

   // response buffer
   srrp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res0      (res0),
      .res1      (res1),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // response fields
   assign rsp_has_packet     = rsp.has_packet;
   assign rsp_tx_dest        = rsp.tx_dest;
   assign rsp_tx_src         = rsp.tx_src;
   assign rsp_tx_opcode      = rsp.tx_opcode;
   assign rsp_tx_temp        = rsp.tx_temp;
   assign rsp_tx_batt        = rsp.tx_batt;
   assign rsp_sleep_request  = rsp.sleep_request;
   assign rsp_pairing_active = rsp.pairing_active;
   assign rsp_current_base   = rsp.current_base;
   assign rsp_store_base     = rsp.store_base;
   assign rsp_led_event      = rsp.led_event;
   assign rsp_last           = rsp.last;

   // checks
   `ASSERT_NEXT(a_accept_gives_beat, clock, reset, req_valid && !req_stall, rsp_valid,
                "accepted request left no response beat")
   `ASSERT_NEXT(a_second_beat_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
                rsp_valid, "second response beat missing")
   `ASSERT_IMPLIES(a_idle_is_last, clock, reset, rsp_valid && !rsp_has_packet, rsp_last,
                   "beat without packet is not final")
   `ASSERT_IMPLIES(a_store_on_reply, clock, reset, rsp_valid && rsp_store_base,
                   rsp_has_packet && rsp_tx_opcode == OP_PAIR_REPLY,
                   "store pulse outside pairing reply")

endmodule
